// File: sv/fqs_pkg.sv
// Shared types and constants for the search-capable FIFO queue.
package fqs_pkg;

    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int ST_W  = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_PAD_W  = OUT_DATA_W - (2 * VAL_W + 1 + POS_W + ST_W + 1);

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_EXEC     = 5'b00010,
        S_POP_WAIT = 5'b00100,
        S_SEARCH   = 5'b01000,
        S_RESULT   = 5'b10000
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic pop_load;
        logic scan;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic go_pop_wait;
        logic go_search;
        logic scan_done;
        logic out_free;
    } stat_t;

endpackage

// File: sv/fifo_queue_with_search.sv
// Top level of the bounded FIFO queue of signed 32-bit values with search.
//
// Commands arrive on the s_axis channel: s_axis_tuser holds the opcode (push, pop or
// search) and s_axis_tdata the value to append or the key to find. Each accepted
// transfer gives exactly one result transfer on the m_axis channel, which carries the
// popped value, the search outcome, a status code, the front value and the empty flag.
// Push, opcode 3, a pop that finds at most one entry and a search of an empty queue
// pass through the execute and result states after acceptance before m_axis_tvalid
// rises. A pop that leaves entries behind adds a pop-wait state (one extra RAM read to
// fetch the new front entry), and search adds a scan state that walks the ring buffer
// one RAM read per cycle until a hit or the last entry. A new command is accepted in
// the cycle after the result is loaded, so none is taken while one is still in flight.
// The result sits in an output register; while the receiver stalls, the next command
// is still accepted and processed, and its result waits until the register is free.
// Reset empties the queue and drops any pending result; the storage is not cleared.
module fifo_queue_with_search #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] popped_value, [32] found, [37:33] position, [39:38] status,
    // [71:40] front_value, [72] is_empty, [79:73] zero
    output logic [79:0] m_axis_tdata
);

    fqs_pkg::cmd_t  cmd;
    fqs_pkg::stat_t stat;

    fqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fqs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_axis_tuser),
        .in_val    (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// File: sv/fqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/fqs_ctrl.sv
// Controller state machine sequencing each queue operation.
module fqs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fqs_pkg::stat_t stat,
    output fqs_pkg::cmd_t  cmd
);

    fqs_pkg::state_t state_reg;
    fqs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fqs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == fqs_pkg::S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            fqs_pkg::S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = fqs_pkg::S_EXEC;
                end
            end
            fqs_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.go_pop_wait)
                begin
                    state_next = fqs_pkg::S_POP_WAIT;
                end
                else if (stat.go_search)
                begin
                    state_next = fqs_pkg::S_SEARCH;
                end
                else
                begin
                    state_next = fqs_pkg::S_RESULT;
                end
            end
            fqs_pkg::S_POP_WAIT:
            begin
                cmd.pop_load = 1'b1;
                state_next   = fqs_pkg::S_RESULT;
            end
            fqs_pkg::S_SEARCH:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = fqs_pkg::S_RESULT;
                end
            end
            fqs_pkg::S_RESULT:
            begin
                cmd.load_out = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = fqs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fqs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/fqs_dp.sv
// Datapath holding the ring pointers, the front value, the scan logic and the result register.
module fqs_dp #(
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fqs_pkg::cmd_t                    cmd,
    output fqs_pkg::stat_t                   stat,
    input  logic [fqs_pkg::OP_W-1:0]         in_op,
    input  logic [fqs_pkg::VAL_W-1:0]        in_val,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fqs_pkg::OUT_DATA_W-1:0]   out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > fqs_pkg::POS_W) ? CW : fqs_pkg::POS_W;

    logic [fqs_pkg::OP_W-1:0]  op_reg;
    logic [fqs_pkg::VAL_W-1:0] val_reg;
    logic [AW-1:0]             head_reg;
    logic [CW-1:0]             count_reg;
    logic [fqs_pkg::VAL_W-1:0] front_reg;
    logic [fqs_pkg::VAL_W-1:0] popped_reg;
    logic [fqs_pkg::ST_W-1:0]  status_reg;
    logic                      found_reg;
    logic [fqs_pkg::POS_W-1:0] pos_reg;
    logic [CW-1:0]             scan_reg;
    logic [AW-1:0]             ptr_reg;
    logic                      out_valid_reg;
    logic [fqs_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [AW-1:0]             head_inc;
    logic [AW-1:0]             ptr_inc;
    logic [AW:0]               tail_sum;
    logic [AW-1:0]             tail_slot;
    logic                      is_full;
    logic                      is_empty;
    logic                      ram_we;
    logic [AW-1:0]             ram_raddr;
    logic [fqs_pkg::VAL_W-1:0] ram_rdata;
    logic                      hit;
    logic [CW-1:0]             scan_inc;
    logic [PW-1:0]             pos_wide;
    logic [fqs_pkg::VAL_W-1:0] front_out;

    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign ptr_inc   = (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign tail_sum  = {1'b0, head_reg} + (AW + 1)'(count_reg);
    assign tail_slot = (tail_sum >= (AW + 1)'(DEPTH)) ?
                       AW'(tail_sum - (AW + 1)'(DEPTH)) : AW'(tail_sum);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign hit       = (ram_rdata == val_reg);
    assign scan_inc  = scan_reg + 1'b1;
    assign pos_wide  = PW'(scan_reg) + 1'b1;
    assign front_out = is_empty ? '0 : front_reg;

    assign ram_we = cmd.exec && (op_reg == fqs_pkg::OP_PUSH) && !is_full;

    always_comb
    begin
        if (cmd.scan)
        begin
            ram_raddr = ptr_reg;
        end
        else if (op_reg == fqs_pkg::OP_POP)
        begin
            ram_raddr = head_inc;
        end
        else
        begin
            ram_raddr = head_reg;
        end
    end

    fqs_ram #(
        .WIDTH (fqs_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_slot),
        .wdata (val_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.go_pop_wait = (op_reg == fqs_pkg::OP_POP) && (count_reg > CW'(1));
    assign stat.go_search   = (op_reg == fqs_pkg::OP_SEARCH) && !is_empty;
    assign stat.scan_done   = hit || (scan_inc == count_reg);
    assign stat.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec && (op_reg == fqs_pkg::OP_PUSH) && !is_full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.exec && (op_reg == fqs_pkg::OP_POP) && !is_empty)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= in_op;
            val_reg <= in_val;
        end
        if (cmd.exec)
        begin
            popped_reg <= '0;
            status_reg <= fqs_pkg::ST_OK;
            found_reg  <= 1'b0;
            pos_reg    <= '0;
            scan_reg   <= '0;
            ptr_reg    <= head_inc;
            case (op_reg)
                fqs_pkg::OP_PUSH:
                begin
                    if (is_full)
                    begin
                        status_reg <= fqs_pkg::ST_FULL;
                    end
                    else if (is_empty)
                    begin
                        front_reg <= val_reg;
                    end
                end
                fqs_pkg::OP_POP:
                begin
                    if (is_empty)
                    begin
                        status_reg <= fqs_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        popped_reg <= front_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.pop_load)
        begin
            front_reg <= ram_rdata;
        end
        if (cmd.scan)
        begin
            scan_reg <= scan_inc;
            ptr_reg  <= ptr_inc;
            if (hit)
            begin
                found_reg <= 1'b1;
                pos_reg   <= pos_wide[fqs_pkg::POS_W-1:0];
            end
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {{fqs_pkg::OUT_PAD_W{1'b0}}, is_empty, front_out, status_reg,
                             pos_reg, found_reg, popped_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
